>>> hdl/wpc_pkg.sv
package wpc_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int TOLERANCE = 100;          // 1 mm in 10 um units
  localparam int HALF_WIDTH_RESET = 10000;
  localparam int QUEUE_DEPTH = 4;
  localparam int PADDR_WIDTH = 4;

  localparam logic [1:0] OP_POINT   = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [1:0] CORNER_ORIGIN = 2'd0;
  localparam logic [1:0] CORNER_XAXIS  = 2'd1;
  localparam logic [1:0] CORNER_ZAXIS  = 2'd2;
  localparam int NUM_CORNERS = 3;

  localparam logic [1:0] REG_CENTER_X   = 2'd0;
  localparam logic [1:0] REG_CENTER_Y   = 2'd1;
  localparam logic [1:0] REG_HALF_WIDTH = 2'd2;

  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_CORNER = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic       in_win;
    logic [1:0] sel;
  } wpc_ctrl_t;

endpackage

>>> hdl/wpc_front.sv
module wpc_front import wpc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic [1:0]                    opcode,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic [1:0]                    corner_select,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic [COORD_WIDTH-2:0]        half_width,
  output logic                          keep,
  output wpc_ctrl_t                     ctrl
);

  logic signed [COORD_WIDTH:0] dx;
  logic signed [COORD_WIDTH:0] dy;
  logic signed [COORD_WIDTH:0] hw_pos;
  logic signed [COORD_WIDTH:0] hw_neg;
  logic                        z_pos;

  assign dx     = (COORD_WIDTH+1)'(point_x) - (COORD_WIDTH+1)'(center_x);
  assign dy     = (COORD_WIDTH+1)'(point_y) - (COORD_WIDTH+1)'(center_y);
  assign hw_pos = $signed({2'b00, half_width});
  assign hw_neg = -hw_pos;
  assign z_pos  = !point_z[COORD_WIDTH-1] && (point_z != '0);

  always_comb begin
    ctrl.op     = opcode;
    ctrl.sel    = corner_select;
    ctrl.in_win = (dx < hw_pos) && (dx > hw_neg) && (dy < hw_pos) && (dy > hw_neg);
    unique case (opcode)
      OP_POINT:   keep = z_pos;
      OP_RESTART: keep = 1'b1;
      OP_QUERY:   keep = (corner_select <= CORNER_ZAXIS);
      default:    keep = 1'b0;
    endcase
  end

endmodule

>>> hdl/wpc_queue.sv
module wpc_queue import wpc_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic [WIDTH-1:0]                   wdata,
  input  logic                               pop,
  output logic [WIDTH-1:0]                   rdata,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count_next;

  assign rdata = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CW'(1);
    end else if (pop && !push) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count_next;
    end
  end

endmodule

>>> hdl/wpc_back.sv
module wpc_back import wpc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  wpc_ctrl_t                     head_ctrl,
  input  logic signed [COORD_WIDTH-1:0] head_x,
  input  logic signed [COORD_WIDTH-1:0] head_y,
  input  logic signed [COORD_WIDTH-1:0] head_z,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          in_window
);

  localparam logic signed [COORD_WIDTH:0] TOL_POS = (COORD_WIDTH+1)'(TOLERANCE);
  localparam logic signed [COORD_WIDTH:0] TOL_NEG = -TOL_POS;

  logic signed [COORD_WIDTH-1:0] cor_x [NUM_CORNERS];
  logic signed [COORD_WIDTH-1:0] cor_y [NUM_CORNERS];
  logic signed [COORD_WIDTH-1:0] cor_z [NUM_CORNERS];

  logic signed [COORD_WIDTH:0] dxk [NUM_CORNERS];
  logic [NUM_CORNERS-1:0]      take;
  logic                        near;
  logic                        x_ok;
  logic                        y_ok;
  logic                        produce;
  logic                        out_valid_next;

  assign pop = head_valid && (!out_valid || out_ready);

  // Each corner compares only against its own stored x and y.
  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      dxk[k]  = (COORD_WIDTH+1)'(head_x) - (COORD_WIDTH+1)'(cor_x[k]);
      near    = (dxk[k] < TOL_POS) && (dxk[k] > TOL_NEG);
      x_ok    = (2'(k) == CORNER_XAXIS) ? (head_x > cor_x[k]) : (head_x < cor_x[k]);
      y_ok    = (2'(k) == CORNER_ZAXIS) ? (head_y < cor_y[k]) : (head_y > cor_y[k]);
      take[k] = head_ctrl.in_win && (x_ok || near) && y_ok;
    end
  end

  always_comb begin
    produce = 1'b0;
    unique case (head_ctrl.op)
      OP_POINT:   produce = 1'b1;
      OP_QUERY:   produce = 1'b1;
      OP_RESTART: produce = 1'b0;
      default:    produce = 1'b0;
    endcase
    if (pop && produce) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int k = 0; k < NUM_CORNERS; k++) begin
        cor_x[k] <= '0;
        cor_y[k] <= '0;
        cor_z[k] <= '0;
      end
    end else begin
      out_valid <= out_valid_next;
      if (pop) begin
        unique case (head_ctrl.op)
          OP_POINT: begin
            for (int k = 0; k < NUM_CORNERS; k++) begin
              if (take[k]) begin
                cor_x[k] <= head_x;
                cor_y[k] <= head_y;
                cor_z[k] <= head_z;
              end
            end
          end
          OP_RESTART: begin
            // keep the z values
            for (int k = 0; k < NUM_CORNERS; k++) begin
              cor_x[k] <= center_x;
              cor_y[k] <= center_y;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && produce) begin
      if (head_ctrl.op == OP_QUERY) begin
        result_kind <= KIND_CORNER;
        out_x       <= cor_x[head_ctrl.sel];
        out_y       <= cor_y[head_ctrl.sel];
        out_z       <= cor_z[head_ctrl.sel];
        in_window   <= 1'b0;
      end else begin
        result_kind <= KIND_POINT;
        out_x       <= head_x;
        out_y       <= head_y;
        out_z       <= head_z;
        in_window   <= head_ctrl.in_win;
      end
    end
  end

endmodule

>>> hdl/window_point_classifier_extremes.sv
// A result is written into the queue and then registered at the output when nothing is ahead
// of it and the output is free.
// Throughput: one item per cycle while the queue is not full; a 4-entry queue between the
// classifier and the corner unit lets either side stall without stopping the other.
// Dropped points and ignored items never enter the queue; a restart produces no result
// and takes one queue slot.
// Reset (rst, synchronous): queue empty, no result pending, corners at zero,
// center 0/0, half width 10000.
module window_point_classifier_extremes import wpc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_WIDTH-1:0]        paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic [1:0]                    corner_select,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          in_window
);

  localparam int CTRL_W = $bits(wpc_ctrl_t);
  localparam int Q_W    = CTRL_W + 3 * COORD_WIDTH;
  localparam int CW     = $clog2(QUEUE_DEPTH + 1);

  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic [COORD_WIDTH-2:0]        half_width;

  logic          keep;
  wpc_ctrl_t     front_ctrl;
  wpc_ctrl_t     head_ctrl;
  logic          q_push;
  logic          q_pop;
  logic [Q_W-1:0] q_wdata;
  logic [Q_W-1:0] q_rdata;
  logic [CW-1:0]  q_count;
  logic signed [COORD_WIDTH-1:0] head_x;
  logic signed [COORD_WIDTH-1:0] head_y;
  logic signed [COORD_WIDTH-1:0] head_z;
  logic           cfg_write;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x   <= '0;
      center_y   <= '0;
      half_width <= (COORD_WIDTH-1)'(HALF_WIDTH_RESET);
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_CENTER_X:   center_x   <= pwdata[COORD_WIDTH-1:0];
        REG_CENTER_Y:   center_y   <= pwdata[COORD_WIDTH-1:0];
        REG_HALF_WIDTH: half_width <= pwdata[COORD_WIDTH-2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CENTER_X:   prdata = 32'(center_x);
      REG_CENTER_Y:   prdata = 32'(center_y);
      REG_HALF_WIDTH: prdata = 32'(half_width);
      default:        prdata = '0;
    endcase
  end

  wpc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .opcode        (opcode),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_z       (point_z),
    .corner_select (corner_select),
    .center_x      (center_x),
    .center_y      (center_y),
    .half_width    (half_width),
    .keep          (keep),
    .ctrl          (front_ctrl)
  );

  assign in_ready = (q_count != CW'(QUEUE_DEPTH));
  assign q_push   = in_valid && in_ready && keep;
  assign q_wdata  = {front_ctrl, point_x, point_y, point_z};

  wpc_queue #(.WIDTH(Q_W)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .count (q_count)
  );

  assign head_ctrl = q_rdata[Q_W-1 -: CTRL_W];
  assign head_x    = q_rdata[3*COORD_WIDTH-1 -: COORD_WIDTH];
  assign head_y    = q_rdata[2*COORD_WIDTH-1 -: COORD_WIDTH];
  assign head_z    = q_rdata[COORD_WIDTH-1:0];

  wpc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_count != '0),
    .head_ctrl   (head_ctrl),
    .head_x      (head_x),
    .head_y      (head_y),
    .head_z      (head_z),
    .center_x    (center_x),
    .center_y    (center_y),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .in_window   (in_window)
  );

  a_queue_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> q_count == $past(q_count) + CW'($past(q_push)) - CW'($past(q_pop)))
    else $error("queue count out of step with push/pop");

  a_corner_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_CORNER) |-> !in_window)
    else $error("corner report carries window flag");

  a_out_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(q_pop))
    else $error("result appeared without a queue pop");

endmodule
